### rtl/srtf_pkg.sv
// Shared constants for the shortest-remaining-time scheduler.
package srtf_pkg;

	localparam int SLOT_W        = 4;   // slot field width
	localparam int CNT_W         = 5;   // process_count register width
	localparam int DEF_MAX_PROCS = 16;
	localparam int DEF_TIME_BITS = 16;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_SCHED = 1'b1;

endpackage

### rtl/srtf_table.sv
// Job table RAM: one write port, one read port, registered read data.
module srtf_table #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/shortest_remaining_time_scheduler_core.sv
// Shortest-remaining-time-first scheduler core: job table, charge and scan control.
//
//  - Input channel (in_valid/in_ready) takes one word per handshake. mode = load
//    writes arrive_tick and burst_time into table slot `slot` and produces no
//    result. mode = schedule carries event_time (the current tick).
//  - Output channel (out_valid/out_ready) returns one word per schedule word:
//    selected_slot, found, selected_remaining (slot/remaining are 0 if !found).
//  - cfg_wr_en/cfg_wr_data write process_count, the number of slots scanned
//    from slot 0 (capped at MAX_PROCS). Write only while the block is idle.
//  - A schedule word first charges the running job (read, then write back its
//    remaining burst, skipped if nothing runs), then scans the table one slot
//    per cycle through the RAM read port, which sets the pace. A load leaves
//    the block idle; after a schedule word, the next word can be taken in the
//    same cycle that out_valid rises.
//  - in_ready is high only while idle; one word is in work at a time. Loads
//    may be taken while a result waits in the output register.
//  - If the receiver stalls, the finished result waits in its final step
//    until the output register frees, and no new word is taken meanwhile.
//  - Reset: process_count = 1, nothing running, last event time 0. The table
//    has no reset; slots must be loaded before they are scanned.
module shortest_remaining_time_scheduler_core #(
	parameter int MAX_PROCS = srtf_pkg::DEF_MAX_PROCS,
	parameter int TIME_BITS = srtf_pkg::DEF_TIME_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_wr_en,
	input  logic [srtf_pkg::CNT_W-1:0]  cfg_wr_data,
	// input words
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [srtf_pkg::SLOT_W-1:0] slot,
	input  logic [TIME_BITS-1:0]        arrive_tick,
	input  logic [TIME_BITS-1:0]        burst_time,
	input  logic [TIME_BITS-1:0]        event_time,
	// result words
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [srtf_pkg::SLOT_W-1:0] selected_slot,
	output logic                        found,
	output logic [TIME_BITS-1:0]        selected_remaining
);

	import srtf_pkg::*;

	localparam int AW = $clog2(MAX_PROCS);
	localparam int EW = 2 * TIME_BITS;
	// the scan limit can never exceed what the count register holds
	localparam int CAP_I = (MAX_PROCS > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_PROCS;
	localparam logic [CNT_W-1:0] LIM_CAP = CNT_W'(CAP_I);

	// controller states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHG_RD = 3'd1;
	localparam logic [2:0] S_CHG_WR = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     cfg_q;
	logic                 running_valid_q;
	logic [AW-1:0]        running_slot_q;
	logic [TIME_BITS-1:0] last_q;
	logic                 out_valid_q;

	// per-event working registers
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     lim_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 hit_q;
	logic [AW-1:0]        best_slot_q;
	logic [TIME_BITS-1:0] best_rem_q;

	// output payload
	logic [SLOT_W-1:0]    res_slot_q;
	logic                 res_found_q;
	logic [TIME_BITS-1:0] res_rem_q;

	// table port
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [EW-1:0]        wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [EW-1:0]        rd_data;
	logic [TIME_BITS-1:0] rd_arr;
	logic [TIME_BITS-1:0] rd_rem;

	logic                 accept;
	logic                 load_ok;
	logic [CNT_W-1:0]     limit;
	logic                 scan_issue;
	logic                 scan_end;
	logic                 out_free;
	logic                 better;
	logic [TIME_BITS-1:0] spent;
	logic [TIME_BITS-1:0] charged;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_ok  = (int'(slot) < MAX_PROCS);
	assign limit    = (cfg_q > LIM_CAP) ? LIM_CAP : cfg_q;
	assign out_free = !out_valid_q || out_ready;

	assign rd_arr = rd_data[EW-1:TIME_BITS];
	assign rd_rem = rd_data[TIME_BITS-1:0];

	// charge arithmetic: elapsed ticks (zero if time ran backwards), saturating subtract
	assign spent   = (now_q >= last_q) ? (now_q - last_q) : '0;
	assign charged = (rd_rem > spent) ? (rd_rem - spent) : '0;

	// scan control
	assign scan_issue = (state_q == S_SCAN) && (idx_q < lim_q);
	assign scan_end   = (state_q == S_SCAN) && !(idx_q < lim_q) && !rd_vld_s1;
	assign better     = rd_vld_s1 && (rd_arr <= now_q) && (rd_rem != '0)
	                    && (!hit_q || (rd_rem < best_rem_q));

	// table access steering: loads and charge write-back never coincide
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(slot);
		wr_data = {arrive_tick, burst_time};
		rd_en   = 1'b0;
		rd_addr = AW'(idx_q);
		case (state_q)
			S_IDLE: begin
				wr_en = accept && (mode == MODE_LOAD) && load_ok;
			end
			S_CHG_RD: begin
				rd_en   = 1'b1;
				rd_addr = running_slot_q;
			end
			S_CHG_WR: begin
				wr_en   = 1'b1;
				wr_addr = running_slot_q;
				wr_data = {rd_arr, charged};
			end
			S_SCAN: begin
				rd_en = scan_issue;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	srtf_table #(
		.DEPTH (MAX_PROCS),
		.WIDTH (EW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cfg_q           <= CNT_RESET;
			running_valid_q <= 1'b0;
			running_slot_q  <= '0;
			last_q          <= '0;
			out_valid_q     <= 1'b0;
			idx_q           <= '0;
			rd_vld_s1       <= 1'b0;
			hit_q           <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= scan_issue;
			if (better) begin
				hit_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (mode == MODE_SCHED)) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= running_valid_q ? S_CHG_RD : S_SCAN;
					end
				end
				S_CHG_RD: begin
					state_q <= S_CHG_WR;
				end
				S_CHG_WR: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						running_valid_q <= hit_q;
						running_slot_q  <= hit_q ? best_slot_q : '0;
						last_q          <= now_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_SCHED)) begin
			now_q <= event_time;
			lim_q <= limit;
		end
		rd_idx_s1 <= AW'(idx_q);
		if (better) begin
			best_slot_q <= rd_idx_s1;
			best_rem_q  <= rd_rem;
		end
		if ((state_q == S_DONE) && out_free) begin
			res_found_q <= hit_q;
			res_slot_q  <= hit_q ? SLOT_W'(best_slot_q) : '0;
			res_rem_q   <= hit_q ? best_rem_q : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign selected_slot      = res_slot_q;
	assign found              = res_found_q;
	assign selected_remaining = res_rem_q;

`ifndef SYNTHESIS
	// a miss reports slot and remaining as zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (selected_slot == '0 && selected_remaining == '0))
		else $error("miss result carries non-zero fields");

	// a hit always names a job with work left
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (selected_remaining != '0))
		else $error("hit result with zero remaining burst");

	// a schedule word blocks the input until it completes
	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == MODE_SCHED) |=> !in_ready)
		else $error("input taken while a schedule word is in work");

	// idle running slot is parked at zero
	a_run_park: assert property (@(posedge clk) disable iff (!arst_n)
		!running_valid_q |-> (running_slot_q == '0))
		else $error("running slot set with nothing running");
`endif

endmodule

### tb/sv/shortest_remaining_time_scheduler_core_test.sv
// Self-checking testbench for the shortest-remaining-time scheduler core.
module shortest_remaining_time_scheduler_core_test;
	import srtf_pkg::*;

	localparam int TW           = DEF_TIME_BITS;
	localparam int NSLOT        = DEF_MAX_PROCS;
	localparam int RANDOM_WORDS = 1826;
	localparam int PHASES       = 12;
	localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
	localparam int SETTLE       = 8;     // a load is written at the clock edge that accepts it
	localparam int TAIL         = 40;    // wait after the last result is returned
	localparam int MAX_REPORTS  = 40;

	// one input word and one result word, at the block's widths
	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] slot;
		logic [TW-1:0]     arrival;
		logic [TW-1:0]     burst;
		logic [TW-1:0]     evt;
	} job_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              found;
		logic [TW-1:0]     remaining;
	} pick_t;

	typedef enum logic { ROW_CFG, ROW_WORD } row_kind_e;

	// directed stimulus row: either a count write or a word, with an optional
	// hand-written result that replaces the predicted one
	typedef struct packed {
		row_kind_e        kind;
		logic [CNT_W-1:0] count;
		job_word_t        w;
		logic             typed;
		pick_t            want;
	} stim_row_t;

	typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_LONG } rx_style_e;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CNT_W-1:0]  cfg_wr_data;
	logic              in_valid;
	logic              in_ready;
	logic              mode;
	logic [SLOT_W-1:0] slot;
	logic [TW-1:0]     arrive_tick;
	logic [TW-1:0]     burst_time;
	logic [TW-1:0]     event_time;
	logic              out_valid;
	logic              out_ready;
	logic [SLOT_W-1:0] selected_slot;
	logic              found;
	logic [TW-1:0]     selected_remaining;

	shortest_remaining_time_scheduler_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.slot              (slot),
		.arrive_tick       (arrive_tick),
		.burst_time        (burst_time),
		.event_time        (event_time),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.selected_slot     (selected_slot),
		.found             (found),
		.selected_remaining(selected_remaining)
	);

	// ---------------------------------------------------------------------
	// Scheduler predictor: own copy of the job table and run state
	// ---------------------------------------------------------------------
	logic [TW-1:0]     job_arrival [NSLOT];
	logic [TW-1:0]     job_left    [NSLOT];
	logic [SLOT_W-1:0] run_slot;
	logic              run_valid;
	logic [TW-1:0]     last_tick;
	logic [CNT_W-1:0]  slots_in_use;

	pick_t pending_picks[$];   // results owed by the block, oldest first

	int errors;
	int loads_sent;
	int scheds_sent;
	int picks_checked;
	int picks_found;
	int settings_used;
	int burst_left;            // words left in the current sender burst
	logic [TW-1:0] now_tick;   // running notion of time for random words

	// Applies one word to the predictor. Returns 1 with the expected result
	// for a schedule word, 0 for a load.
	function automatic bit srtf_step(input job_word_t w, output pick_t p);
		logic [TW-1:0] spent;
		int            limit;
		bit            hit;
		p = '0;
		if (w.mode == MODE_LOAD) begin
			job_arrival[w.slot] = w.arrival;
			job_left[w.slot]    = w.burst;
			return 1'b0;
		end
		// charge whoever ran since the last event; time going back counts as none
		if (run_valid) begin
			spent = (w.evt >= last_tick) ? TW'(w.evt - last_tick) : '0;
			job_left[run_slot] = (job_left[run_slot] > spent) ?
				TW'(job_left[run_slot] - spent) : '0;
		end
		// counts above the table size scan the whole table; zero scans nothing
		limit = (int'(slots_in_use) > NSLOT) ? NSLOT : int'(slots_in_use);
		hit   = 1'b0;
		for (int i = 0; i < limit; i++) begin
			// strict < keeps the lowest slot on a tie
			if (job_arrival[i] <= w.evt && job_left[i] != '0 &&
					(!hit || job_left[i] < p.remaining)) begin
				hit         = 1'b1;
				p.remaining = job_left[i];
				p.slot      = SLOT_W'(i);
			end
		end
		p.found   = hit;
		run_valid = hit;
		run_slot  = p.slot;
		last_tick = w.evt;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic stim_row_t load_row(int s, logic [TW-1:0] arr, logic [TW-1:0] len);
		stim_row_t r;
		r           = '0;
		r.kind      = ROW_WORD;
		r.w.mode    = MODE_LOAD;
		r.w.slot    = SLOT_W'(s);
		r.w.arrival = arr;
		r.w.burst   = len;
		r.w.evt     = TW'($urandom);   // don't-care field, keep it moving
		return r;
	endfunction

	function automatic stim_row_t sched_row(logic [TW-1:0] tick_now, bit typed, int s,
			bit hit, logic [TW-1:0] rem);
		stim_row_t r;
		r                = '0;
		r.kind           = ROW_WORD;
		r.w.mode         = MODE_SCHED;
		r.w.slot         = SLOT_W'($urandom);
		r.w.arrival      = TW'($urandom);
		r.w.burst        = TW'($urandom);
		r.w.evt          = tick_now;
		r.typed          = typed;
		r.want.slot      = SLOT_W'(s);
		r.want.found     = hit;
		r.want.remaining = rem;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(int count);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_CFG;
		r.count = CNT_W'(count);
		return r;
	endfunction

	// Random word. Mostly loads of jobs that arrive soon with short bursts and
	// schedule events with time moving forward; the rest is noise: jumps,
	// backward time, zero and full-scale bursts, far-off arrivals.
	function automatic job_word_t draw_job_word();
		job_word_t w;
		int        roll;
		w.slot    = SLOT_W'($urandom);
		w.arrival = TW'($urandom);
		w.burst   = TW'($urandom);
		w.evt     = TW'($urandom);
		roll      = $urandom_range(0, 99);
		if (roll < 45) begin
			w.mode = MODE_LOAD;
			roll   = $urandom_range(0, 9);
			if (roll < 7)
				w.arrival = TW'(now_tick + TW'($urandom_range(0, 80)));
			else if (roll == 7)
				w.arrival = '1;
			else if (roll == 8)
				w.arrival = '0;
			roll = $urandom_range(0, 19);
			if (roll == 0)
				w.burst = '0;
			else if (roll == 1)
				w.burst = '1;
			else if (roll > 3)
				w.burst = TW'($urandom_range(1, 150));
		end else begin
			w.mode = MODE_SCHED;
			roll   = $urandom_range(0, 99);
			if (roll < 3) begin
				now_tick = TW'($urandom);
				w.evt    = now_tick;
			end else if (roll < 8) begin
				w.evt = TW'(now_tick - TW'($urandom_range(1, 60)));
			end else begin
				now_tick = TW'(now_tick + TW'($urandom_range(0, 40)));
				w.evt    = now_tick;
			end
		end
		return w;
	endfunction

	// Offers one word, holding it until accepted; bursts and gaps are decided
	// here. Returns at the clock edge where the word was taken.
	task automatic send_word(input job_word_t w, input bit typed, input pick_t want);
		pick_t p;
		int    gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
				$urandom_range(1, 30);
		end
		burst_left--;
		in_valid     <= 1'b1;
		mode         <= w.mode;
		slot         <= w.slot;
		arrive_tick  <= w.arrival;
		burst_time   <= w.burst;
		event_time   <= w.evt;
		do @(posedge clk); while (!in_ready);
		if (srtf_step(w, p)) begin
			pending_picks.push_back(typed ? want : p);
			scheds_sent++;
		end else begin
			loads_sent++;
		end
	endtask

	// Sender holds off until the block has returned everything owed.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_picks.size() != 0);
	endtask

	// process_count may only change with the block idle; a trailing load is
	// written when it is accepted, so the settle time is only margin.
	task automatic set_slot_count(input logic [CNT_W-1:0] count);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		slots_in_use = count;
		settings_used++;
	endtask

	function automatic void check_field(string name, logic [TW-1:0] want, logic [TW-1:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Receiver: picks a new stall style at random, among always ready,
	// coin-flip, or mostly ready with occasional long holds
	// ---------------------------------------------------------------------
	rx_style_e rx_style = RX_OPEN;
	int        rx_cycle = 0;
	int        rx_hold  = 0;

	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 300 == 0)
			rx_style = rx_style_e'($urandom_range(0, 2));
		if (rx_hold != 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_COIN: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						rx_hold   = $urandom_range(5, 40);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Result checker: every accepted result word against the oldest owed one
	// ---------------------------------------------------------------------
	pick_t mon_want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_picks.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, got slot %0d found %0b remaining %0h",
						$time, selected_slot, found, selected_remaining);
			end else begin
				mon_want = pending_picks.pop_front();
				check_field("selected_slot", TW'(mon_want.slot), TW'(selected_slot));
				check_field("found", TW'(mon_want.found), TW'(found));
				check_field("selected_remaining", mon_want.remaining, selected_remaining);
				picks_checked++;
				if (mon_want.found)
					picks_found++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: too long without a word moving on either channel
	// ---------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending_picks.size());
			$display("[shortest_remaining_time_scheduler_core] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		stim_row_t rows[$];
		pick_t     no_pick;
		int        per_phase;
		int        count;

		errors        = 0;
		loads_sent    = 0;
		scheds_sent   = 0;
		picks_checked = 0;
		picks_found   = 0;
		settings_used = 0;
		burst_left    = 0;
		now_tick      = '0;
		no_pick       = '0;

		// predictor after reset
		run_valid    = 1'b0;
		run_slot     = '0;
		last_tick    = '0;
		slots_in_use = CNT_RESET;
		for (int i = 0; i < NSLOT; i++) begin
			job_arrival[i] = '0;
			job_left[i]    = '0;
		end

		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= '0;
		in_valid     <= 1'b0;
		mode         <= MODE_LOAD;
		slot         <= '0;
		arrive_tick  <= '0;
		burst_time   <= '0;
		event_time   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Slot 0 is loaded first so the reset count of one
		// never scans an empty slot; the rest are loaded under a count of zero.
		rows.push_back(load_row(0, 16'h0000, 16'hFFFF));
		// reset count scans slot 0 only, nothing running yet
		rows.push_back(sched_row(16'h0000, 1'b1, 0, 1'b1, 16'hFFFF));
		// slot 0 ran for 16 ticks
		rows.push_back(sched_row(16'h0010, 1'b1, 0, 1'b1, 16'hFFEF));
		rows.push_back(cfg_row(0));
		// count zero: slot 0 is still charged, but nothing is found
		rows.push_back(sched_row(16'h0020, 1'b1, 0, 1'b0, 16'h0000));
		// nothing running now, so no charge and nothing found
		rows.push_back(sched_row(16'h0030, 1'b1, 0, 1'b0, 16'h0000));
		// slot 1 has no work; 5 and 9 tie; 15 arrives only at the last tick
		for (int s = 1; s < NSLOT; s++) begin
			if (s == 1)
				rows.push_back(load_row(s, 16'h0000, 16'h0000));
			else if (s == NSLOT - 1)
				rows.push_back(load_row(s, 16'hFFFF, 16'h0001));
			else if (s == 5 || s == 9)
				rows.push_back(load_row(s, TW'(s * 16), 16'h0100));
			else
				rows.push_back(load_row(s, TW'(s * 16), TW'(16'h1000 + s)));
		end
		// count above the table size scans all sixteen slots
		rows.push_back(cfg_row(31));
		rows.push_back(sched_row(16'h0040, 1'b0, 0, 1'b0, 16'h0000));
		rows.push_back(sched_row(16'hFFFF, 1'b0, 0, 1'b0, 16'h0000));
		// time going backwards charges nothing
		rows.push_back(sched_row(16'h0005, 1'b0, 0, 1'b0, 16'h0000));
		// slots 5 and 9 tie on remaining work: lower slot wins
		rows.push_back(sched_row(16'h0100, 1'b0, 0, 1'b0, 16'h0000));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				set_slot_count(rows[i].count);
			else
				send_word(rows[i].w, rows[i].typed, rows[i].want);
		end
		now_tick = 16'h0100;

		// Random part, in phases with a fresh count each; every slot is loaded
		// by now, so any count is safe.
		per_phase = RANDOM_WORDS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       count = 16;
				1:       count = 1;
				2:       count = 31;
				3:       count = 0;
				4:       count = 2;
				5:       count = 17;
				default: count = $urandom_range(0, 31);
			endcase
			set_slot_count(CNT_W'(count));
			for (int k = 0; k < per_phase; k++) begin
				// now and then let the pipeline run dry mid-phase
				if ($urandom_range(0, 99) == 0)
					drain_results();
				send_word(draw_job_word(), 1'b0, no_pick);
			end
		end

		drain_results();
		repeat (TAIL) @(posedge clk);

		$display("Sent %0d load and %0d schedule words over %0d slot-count settings.",
			loads_sent, scheds_sent, settings_used);
		$display("Checked %0d results, %0d of them with a job selected; %0d mismatches.",
			picks_checked, picks_found, errors);
		if (errors == 0 && pending_picks.size() == 0) begin
			$display("[shortest_remaining_time_scheduler_core] OK");
		end else begin
			$display("[shortest_remaining_time_scheduler_core] ERROR");
		end
		$finish;
	end

endmodule
